FILE: hw/rtl/mld_pkg.sv
// Shared types and constants for the marker and length deframer.
package mld_pkg;

  localparam int BYTE_W     = 8;
  localparam int MARKER_W   = 32;
  localparam int LEN_W      = 10;
  localparam int WIN_BYTES  = 4;
  localparam int HEAD_BYTES = 8;

  // Configuration register indexes.
  typedef enum logic {
    REG_HEAD_MARKER = 1'b0,
    REG_TAIL_MARKER = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_NO_MARKER = 2'd1,
    ST_ORDER     = 2'd2,
    ST_LENGTH    = 2'd3
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              is_verdict;
    status_t           frame_status;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

  // Up to two results per input item; when only one is present it is in first.
  typedef struct packed {
    logic    first_en;
    logic    second_en;
    result_t first;
    result_t second;
  } push_t;

endpackage

FILE: hw/rtl/mld_core.sv
// Per-datagram framing state: marker search, length capture, payload window, verdict.
module mld_core #(
  parameter int MAX_DATAGRAM = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [mld_pkg::BYTE_W-1:0]     data_byte,
  input  logic                           end_of_datagram,
  input  logic [mld_pkg::MARKER_W-1:0]   head_marker,
  input  logic [mld_pkg::MARKER_W-1:0]   tail_marker,
  output mld_pkg::push_t                 push
);

  localparam int IDX_W = $clog2(MAX_DATAGRAM + 1);

  logic [mld_pkg::MARKER_W-1:0] byte_window;
  logic [IDX_W-1:0]             byte_index;
  logic [IDX_W-1:0]             head_start;
  logic [IDX_W-1:0]             tail_start;
  logic                         head_seen;
  logic                         tail_seen;
  logic [mld_pkg::MARKER_W-1:0] length_field;
  logic [IDX_W-1:0]             forwarded_count;

  logic [mld_pkg::MARKER_W-1:0] byte_window_next;
  logic [IDX_W-1:0]             byte_index_next;
  logic [IDX_W-1:0]             head_start_next;
  logic [IDX_W-1:0]             tail_start_next;
  logic                         head_seen_next;
  logic                         tail_seen_next;
  logic [mld_pkg::MARKER_W-1:0] length_field_next;
  logic [IDX_W-1:0]             forwarded_count_next;

  logic                         active;
  logic                         in_body;
  logic                         fwd;
  logic [IDX_W:0]               idx_ext;
  logic [IDX_W-1:0]             span;
  mld_pkg::status_t             status;
  mld_pkg::result_t             pay_res;
  mld_pkg::result_t             ver_res;

  always_comb begin
    active  = byte_index < IDX_W'(MAX_DATAGRAM);
    idx_ext = {1'b0, byte_index};

    // The byte leaving the window sits at byte_index-4; it is payload when it
    // lies at or past head+8 and before the tail, if the tail has been found.
    in_body = (idx_ext >= ({1'b0, head_start} + (IDX_W+1)'(mld_pkg::HEAD_BYTES
                + mld_pkg::WIN_BYTES)))
              && (!tail_seen
                  || idx_ext < ({1'b0, tail_start} + (IDX_W+1)'(mld_pkg::WIN_BYTES)));
    fwd = step && active && head_seen && in_body;

    byte_window_next     = byte_window;
    byte_index_next      = byte_index;
    head_start_next      = head_start;
    tail_start_next      = tail_start;
    head_seen_next       = head_seen;
    tail_seen_next       = tail_seen;
    length_field_next    = length_field;
    forwarded_count_next = forwarded_count + IDX_W'(fwd);

    if (step && active) begin
      byte_window_next = {data_byte, byte_window[mld_pkg::MARKER_W-1:mld_pkg::BYTE_W]};
      if (byte_index >= IDX_W'(mld_pkg::WIN_BYTES - 1)) begin
        if (!head_seen && byte_window_next == head_marker) begin
          head_seen_next  = 1'b1;
          head_start_next = byte_index - IDX_W'(mld_pkg::WIN_BYTES - 1);
        end
        if (!tail_seen && byte_window_next == tail_marker) begin
          tail_seen_next  = 1'b1;
          tail_start_next = byte_index - IDX_W'(mld_pkg::WIN_BYTES - 1);
        end
      end
      // A head found on this very byte cannot end its length field here too.
      if (head_seen
          && idx_ext == {1'b0, head_start} + (IDX_W+1)'(mld_pkg::HEAD_BYTES - 1)) begin
        length_field_next = byte_window_next;
      end
      byte_index_next = byte_index + IDX_W'(1);
    end

    span = tail_start_next - head_start_next - IDX_W'(mld_pkg::HEAD_BYTES);
    priority if (!head_seen_next || !tail_seen_next) begin
      status = mld_pkg::ST_NO_MARKER;
    end else if (head_start_next >= tail_start_next) begin
      status = mld_pkg::ST_ORDER;
    end else if (({1'b0, tail_start_next} <
                  {1'b0, head_start_next} + (IDX_W+1)'(mld_pkg::HEAD_BYTES))
                 || length_field_next != mld_pkg::MARKER_W'(span)) begin
      status = mld_pkg::ST_LENGTH;
    end else begin
      status = mld_pkg::ST_ACCEPTED;
    end

    pay_res.payload_byte   = byte_window[mld_pkg::BYTE_W-1:0];
    pay_res.is_verdict     = 1'b0;
    pay_res.frame_status   = mld_pkg::ST_ACCEPTED;
    pay_res.payload_length = '0;

    ver_res.payload_byte   = '0;
    ver_res.is_verdict     = 1'b1;
    ver_res.frame_status   = status;
    ver_res.payload_length = (status == mld_pkg::ST_ACCEPTED)
                             ? mld_pkg::LEN_W'(forwarded_count_next) : '0;

    push.first_en  = fwd || (step && end_of_datagram);
    push.second_en = fwd && step && end_of_datagram;
    push.first     = fwd ? pay_res : ver_res;
    push.second    = ver_res;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_datagram)) begin
      byte_window     <= '0;
      byte_index      <= '0;
      head_start      <= '0;
      tail_start      <= '0;
      head_seen       <= 1'b0;
      tail_seen       <= 1'b0;
      length_field    <= '0;
      forwarded_count <= '0;
    end else if (step) begin
      byte_window     <= byte_window_next;
      byte_index      <= byte_index_next;
      head_start      <= head_start_next;
      tail_start      <= tail_start_next;
      head_seen       <= head_seen_next;
      tail_seen       <= tail_seen_next;
      length_field    <= length_field_next;
      forwarded_count <= forwarded_count_next;
    end
  end

endmodule

FILE: hw/rtl/mld_fifo.sv
// Four-entry result queue taking up to two results per cycle and giving one.
module mld_fifo (
  input  logic             clk,
  input  logic             rst,
  input  mld_pkg::push_t   push,
  output logic             room,
  output logic             result_valid,
  input  logic             result_stall,
  output mld_pkg::result_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  mld_pkg::result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic [PTR_W:0]   count_next;
  logic             pop;

  always_comb begin
    room         = count <= (PTR_W+1)'(DEPTH - 2);
    result_valid = count != '0;
    pop          = result_valid && !result_stall;
    head         = mem[rd_ptr];
    count_next   = count + (PTR_W+1)'(push.first_en) + (PTR_W+1)'(push.second_en)
                   - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.first_en) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.second_en) begin
      mem[wr_ptr + PTR_W'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.first_en) + PTR_W'(push.second_en);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

endmodule

FILE: hw/rtl/marker_length_deframer.sv
// Top level of the head-marker, length and tail-marker datagram deframer.
//
// Usage: datagram bytes enter one per item on the byte channel (byte_valid,
// byte_stall, data_byte, end_of_datagram). Results leave on the result
// channel (result_valid, result_stall and the four result fields). A byte
// that lies between the length field and the tail marker comes out as a
// tentative payload item four bytes later; the last byte of a datagram also
// produces a verdict item, after any payload item of the same byte.
// The head and tail markers are to be written through the configuration port
// while the block is idle; the block itself does not enforce this. Index 0 is
// the head marker, index 1 the tail marker. A byte that is taken waits in the
// input register until the result queue has room; its results are then
// written into the queue, whose head is offered to the receiver.
// Throughput: one byte per cycle while the result queue has room, set by
// the single pass from the input register through the framing logic into
// the four-entry result queue; the output side drains one item per cycle
// while not stalled, and a closing byte that also releases payload gives two items.
// Reset clears both markers, all per-datagram state and the queue.
// When the receiver stalls, the queue fills; once it cannot take two more
// results the input register holds its byte and byte_stall rises.
module marker_length_deframer #(
  parameter int MAX_DATAGRAM = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  output logic                         byte_stall,
  input  logic [mld_pkg::BYTE_W-1:0]   data_byte,
  input  logic                         end_of_datagram,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [mld_pkg::BYTE_W-1:0]   payload_byte,
  output logic                         is_verdict,
  output logic [1:0]                   frame_status,
  output logic [mld_pkg::LEN_W-1:0]    payload_length,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [mld_pkg::MARKER_W-1:0] cfg_data
);

  logic [mld_pkg::MARKER_W-1:0] head_marker;
  logic [mld_pkg::MARKER_W-1:0] tail_marker;

  // Input register: holds one byte until the queue has room for its results.
  logic                       item_valid;
  logic [mld_pkg::BYTE_W-1:0] item_byte;
  logic                       item_last;

  logic             room;
  logic             step;
  logic             accept;
  mld_pkg::push_t   push;
  mld_pkg::result_t head;

  assign step       = item_valid && room;
  assign byte_stall = item_valid && !room;
  assign accept     = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_marker <= '0;
      tail_marker <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mld_pkg::REG_HEAD_MARKER: head_marker <= cfg_data;
        mld_pkg::REG_TAIL_MARKER: tail_marker <= cfg_data;
        default:                  head_marker <= head_marker;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (step) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= data_byte;
      item_last <= end_of_datagram;
    end
  end

  mld_core #(
    .MAX_DATAGRAM(MAX_DATAGRAM)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .data_byte       (item_byte),
    .end_of_datagram (item_last),
    .head_marker     (head_marker),
    .tail_marker     (tail_marker),
    .push            (push)
  );

  mld_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room         (room),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .head         (head)
  );

  assign payload_byte   = head.payload_byte;
  assign is_verdict     = head.is_verdict;
  assign frame_status   = head.frame_status;
  assign payload_length = head.payload_length;

endmodule

FILE: tb/mld_frame_checker.sv
// Scoreboard that predicts and checks the deframer's result items.
module mld_frame_checker #(
  parameter int MAX_DATAGRAM = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         byte_valid,
  input  logic                         byte_stall,
  input  logic [mld_pkg::BYTE_W-1:0]   data_byte,
  input  logic                         end_of_datagram,
  input  logic                         result_valid,
  input  logic                         result_stall,
  input  logic [mld_pkg::BYTE_W-1:0]   payload_byte,
  input  logic                         is_verdict,
  input  logic [1:0]                   frame_status,
  input  logic [mld_pkg::LEN_W-1:0]    payload_length,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [mld_pkg::MARKER_W-1:0] cfg_data,
  output int unsigned                  pending,
  output int unsigned                  mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  import mld_pkg::*;

  localparam int IDX_W = $clog2(MAX_DATAGRAM) + 1;

  logic [MARKER_W-1:0] head_mk;
  logic [MARKER_W-1:0] tail_mk;
  logic [MARKER_W-1:0] window;
  logic [MARKER_W-1:0] length_word;
  logic [IDX_W-1:0]    pos;
  logic [IDX_W-1:0]    head_pos;
  logic [IDX_W-1:0]    tail_pos;
  logic [IDX_W-1:0]    fwd_count;
  logic                got_head;
  logic                got_tail;

  result_t     due_results[$];
  int unsigned mismatch_count = 0;

  initial pending = 0;
  initial mismatches = 0;

  task automatic clear_frame();
    window      = '0;
    length_word = '0;
    pos         = '0;
    head_pos    = '0;
    tail_pos    = '0;
    fwd_count   = '0;
    got_head    = 1'b0;
    got_tail    = 1'b0;
  endtask

  // Works out the result items that one accepted byte releases.
  task automatic deframe_byte(input logic [BYTE_W-1:0] b, input logic closing);
    result_t          r;
    status_t          verdict;
    logic [IDX_W-1:0] p;
    if (pos < MAX_DATAGRAM) begin
      // The byte leaving the window sits four places behind the newest one.
      if (pos >= WIN_BYTES && got_head) begin
        p = IDX_W'(pos - WIN_BYTES);
        if (p >= head_pos + HEAD_BYTES && (!got_tail || p < tail_pos)) begin
          r = '0;
          r.payload_byte = window[BYTE_W-1:0];
          due_results.push_back(r);
          fwd_count++;
        end
      end
      window = {b, window[MARKER_W-1:BYTE_W]};
      if (pos >= WIN_BYTES - 1) begin
        if (!got_head && window == head_mk) begin
          got_head = 1'b1;
          head_pos = IDX_W'(pos - (WIN_BYTES - 1));
        end
        if (!got_tail && window == tail_mk) begin
          got_tail = 1'b1;
          tail_pos = IDX_W'(pos - (WIN_BYTES - 1));
        end
      end
      if (got_head && pos == head_pos + HEAD_BYTES - 1) length_word = window;
      pos++;
    end
    if (closing) begin
      if (!got_head || !got_tail) verdict = ST_NO_MARKER;
      else if (head_pos >= tail_pos) verdict = ST_ORDER;
      else if (tail_pos < head_pos + HEAD_BYTES ||
               length_word != tail_pos - head_pos - HEAD_BYTES) verdict = ST_LENGTH;
      else verdict = ST_ACCEPTED;
      r = '0;
      r.is_verdict   = 1'b1;
      r.frame_status = verdict;
      if (verdict == ST_ACCEPTED) r.payload_length = fwd_count[LEN_W-1:0];
      due_results.push_back(r);
      clear_frame();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      head_mk = '0;
      tail_mk = '0;
      clear_frame();
      due_results.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_HEAD_MARKER) head_mk = cfg_data;
        else tail_mk = cfg_data;
      end
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $error("result item with none due: payload_byte %0d is_verdict %0d %s %0d %s %0d",
                 payload_byte, is_verdict, "frame_status", frame_status,
                 "payload_length", payload_length);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
          check_field("is_verdict", 32'(want.is_verdict), 32'(is_verdict));
          check_field("frame_status", 32'(want.frame_status), 32'(frame_status));
          check_field("payload_length", 32'(want.payload_length), 32'(payload_length));
        end
      end
      if (byte_valid && !byte_stall) deframe_byte(data_byte, end_of_datagram);
    end
    pending    <= due_results.size();
    mismatches <= mismatch_count;
  end

endmodule

FILE: tb/marker_length_deframer_tb.sv
// Testbench top: clock, reset, datagram stimulus and the final verdict for the deframer.
module marker_length_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mld_pkg::*;

  localparam int PERIOD_NS      = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int DATAGRAM_LIMIT = 1024;
  // Extra cycles to wait once no result is pending.
  localparam int SETTLE_CYCLES  = 4;
  localparam int RUN_LIMIT_NS   = 2_000_000;
  localparam int MAX_PAYLOAD    = 24;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                end_of_datagram = 1'b0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [BYTE_W-1:0]   payload_byte;
  logic                is_verdict;
  logic [1:0]          frame_status;
  logic [LEN_W-1:0]    payload_length;
  logic                cfg_write = 1'b0;
  logic                cfg_index = 1'b0;
  logic [MARKER_W-1:0] cfg_data = '0;

  int unsigned pending;
  int unsigned mismatches;

  // Percentages of cycles in which the sender holds back an item and the receiver stalls.
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned bytes_sent = 0;
  int unsigned dgrams_sent = 0;
  int unsigned marker_settings = 0;

  // Markers currently programmed, so that frames can be built around them.
  logic [MARKER_W-1:0] head_sel = '0;
  logic [MARKER_W-1:0] tail_sel = '0;

  // The datagram being assembled, in wire order.
  logic [BYTE_W-1:0] dgram[$];

  always #(PERIOD_NS / 2) clk = ~clk;

  marker_length_deframer #(
    .MAX_DATAGRAM(DATAGRAM_LIMIT)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .end_of_datagram(end_of_datagram),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .payload_byte   (payload_byte),
    .is_verdict     (is_verdict),
    .frame_status   (frame_status),
    .payload_length (payload_length),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  mld_frame_checker #(
    .MAX_DATAGRAM(DATAGRAM_LIMIT)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .data_byte      (data_byte),
    .end_of_datagram(end_of_datagram),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .payload_byte   (payload_byte),
    .is_verdict     (is_verdict),
    .frame_status   (frame_status),
    .payload_length (payload_length),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pending        (pending),
    .mismatches     (mismatches)
  );

  // The receiver decides afresh at every edge whether to stall, so stalls land on
  // payload items and verdict items alike, and on back-to-back pairs.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offers one byte, possibly after a random gap, and returns at the edge where it is
  // taken. Stall is read just after the edge, so it is the value the block saw there.
  task automatic put_byte(input logic [BYTE_W-1:0] b, input logic closing);
    while ($urandom_range(99) < gap_pct) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid      <= 1'b1;
    data_byte       <= b;
    end_of_datagram <= closing;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Appends a 32-bit word least significant byte first, as markers and lengths travel.
  task automatic add_word(input logic [MARKER_W-1:0] w);
    for (int k = 0; k < WIN_BYTES; k++) dgram.push_back(w[BYTE_W*k +: BYTE_W]);
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) dgram.push_back(BYTE_W'($urandom_range(255)));
  endtask

  // Sends the assembled datagram with the end mark on its final byte.
  task automatic send_dgram();
    if (dgram.size() == 0) add_noise(1);
    foreach (dgram[k]) put_byte(dgram[k], k == dgram.size() - 1);
    dgram.delete();
    dgrams_sent++;
  endtask

  // Stops offering items and waits until every predicted result has come out. The
  // first edge lets the scoreboard count the byte that was taken just now.
  task automatic wait_drained();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both markers; only called while the block is idle.
  task automatic set_markers(input logic [MARKER_W-1:0] head, input logic [MARKER_W-1:0] tail);
    cfg_write <= 1'b1;
    cfg_index <= REG_HEAD_MARKER;
    cfg_data  <= head;
    @(posedge clk);
    cfg_index <= REG_TAIL_MARKER;
    cfg_data  <= tail;
    @(posedge clk);
    cfg_write <= 1'b0;
    head_sel = head;
    tail_sel = tail;
    marker_settings++;
  endtask

  // Most datagrams are well-formed frames with random content; the rest break the
  // frame in one of the ways the verdict distinguishes, or are plain noise.
  task automatic random_dgram();
    int unsigned n;
    n = $urandom_range(MAX_PAYLOAD);
    if ($urandom_range(99) < 70) begin
      add_noise($urandom_range(3));
      add_word(head_sel);
      add_word(n);
      add_noise(n);
      add_word(tail_sel);
      add_noise($urandom_range(3));
    end else begin
      case ($urandom_range(5))
        0: begin
          // Length that disagrees with the marker distance, by one bit or entirely.
          add_word(head_sel);
          if ($urandom_range(1)) add_word(n ^ (32'd1 << $urandom_range(31)));
          else add_word($urandom);
          add_noise(n);
          add_word(tail_sel);
        end
        1: begin
          // No head marker at all.
          add_noise($urandom_range(3));
          add_word(n);
          add_noise(n);
          add_word(tail_sel);
        end
        2: begin
          // Head and payload, but the datagram ends before any tail marker.
          add_word(head_sel);
          add_word(n);
          add_noise(n);
          add_noise($urandom_range(3));
        end
        3: begin
          // Tail marker ahead of the head marker.
          add_noise($urandom_range(3));
          add_word(tail_sel);
          add_noise($urandom_range(3));
          add_word(head_sel);
          add_word(n);
          add_noise(n);
        end
        4: begin
          // Tail marker inside the length field or just after the head.
          add_word(head_sel);
          add_noise($urandom_range(3));
          add_word(tail_sel);
        end
        default: add_noise($urandom_range(1, 20));
      endcase
    end
    send_dgram();
  endtask

  task automatic random_bytes(input int unsigned budget);
    int unsigned stop_at;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) random_dgram();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sender gaps are light and the receiver stalls most of the time.
    gap_pct   = 20;
    stall_pct = 73;

    // Both markers are still zero from reset. Two zero bytes match them, but a marker
    // is only looked for once four bytes are in, so the verdict is a missing marker.
    dgram.push_back('0);
    dgram.push_back('0);
    send_dgram();
    // Four zero bytes find head and tail at the same place: head not before tail.
    repeat (WIN_BYTES) dgram.push_back('0);
    send_dgram();
    wait_drained();

    set_markers('1, $urandom);
    // The shortest frame that is accepted: head, zero length, tail.
    add_word(head_sel);
    add_word('0);
    add_word(tail_sel);
    send_dgram();
    // A tail straight after the head is too close for a length field.
    add_word(head_sel);
    add_word(tail_sel);
    send_dgram();

    random_bytes(270);
    wait_drained();

    // The sender now idles most of the time and the receiver rarely stalls.
    gap_pct   = 73;
    stall_pct = 20;
    set_markers($urandom, '0);
    random_bytes(270);
    wait_drained();

    // No idling on either side.
    gap_pct   = 0;
    stall_pct = 0;
    set_markers($urandom, $urandom);
    // The largest frame fills the datagram limit exactly; the bytes after it, tail
    // marker among them, lie past the limit and must be ignored up to the end mark.
    add_word(head_sel);
    add_word(DATAGRAM_LIMIT - 3 * WIN_BYTES);
    add_noise(DATAGRAM_LIMIT - 3 * WIN_BYTES);
    add_word(tail_sel);
    add_word(tail_sel);
    add_noise(2);
    send_dgram();
    random_bytes(100);
    wait_drained();

    $display("Sent %0d bytes in %0d datagrams under %0d marker settings,",
             bytes_sent, dgrams_sent, marker_settings);
    $display("with idling on the byte side, on the result side, and on neither.");
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
